FILE: rtl/core/apyd_pkg.sv
// shared types and constants for the yaw packet parser
package apyd_pkg;

	localparam int unsigned WINDOW_BYTES = 33;
	localparam logic [7:0] HDR_BYTE = 8'h55;
	localparam logic [7:0] ANGLE_TAG = 8'h53;
	localparam int unsigned HDR_OFS_A = 0;
	localparam int unsigned HDR_OFS_B = 11;
	localparam int unsigned HDR_OFS_C = 22;
	localparam int unsigned TAG_OFS = 23;
	localparam int unsigned SUM_FIRST = 24;
	localparam int unsigned SUM_BYTES = 8;
	localparam int unsigned YAW_LO_OFS = 28;
	localparam int unsigned YAW_HI_OFS = 29;
	localparam int unsigned CHK_OFS = 32;
	localparam logic signed [16:0] WRAP_LIMIT = 17'sd54613;
	localparam logic [16:0] FULL_TURN = 17'h10000;

	typedef logic [7:0] byte_t;
	typedef logic [15:0] yaw_t;
	typedef logic signed [16:0] offset_t;

	// queue status seen by the front and back ends
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

FILE: rtl/core/angle_packet_yaw_delta_parser_top.sv
// top level of the yaw packet parser
//
// channel   direction  handshake          payload
// input     in         push / full        rx_byte[7:0]
// result    out        empty / pop        heading[15:0], yaw_offset[16:0] signed
// config    in         cfg_write          cfg_data[15:0] (yaw reference)
//
// one byte per cycle while full is low; a match is pushed to the queue in the cycle its byte is taken
// a result then waits in the queue until the output register is empty or being popped
// full follows the word queue, which fills only while pop is held low
// reset clears the byte window, the reference and the queue, and marks the output register empty
module angle_packet_yaw_delta_parser_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [7:0]   rx_byte,
	output logic         empty,
	input  logic         pop,
	output logic [15:0]  heading,
	output logic signed [16:0] yaw_offset,
	input  logic         cfg_write,
	input  logic [15:0]  cfg_data
);

	apyd_pkg::qstat_t qstat;
	logic             q_push;
	logic             q_pop;
	apyd_pkg::yaw_t   q_data;
	apyd_pkg::yaw_t   q_head;

	assign full = qstat.full;

	apyd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.qstat   (qstat),
		.q_push  (q_push),
		.q_data  (q_data)
	);

	apyd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_data (q_data),
		.q_pop  (q_pop),
		.q_head (q_head),
		.qstat  (qstat)
	);

	apyd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_data   (cfg_data),
		.qstat      (qstat),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.heading    (heading),
		.yaw_offset (yaw_offset)
	);

`ifndef SYNTHESIS
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("word pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qstat.empty)
		else $error("word popped from an empty queue");

	a_offset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (yaw_offset <= 17'sd54613 && yaw_offset >= -17'sd54613))
		else $error("yaw offset outside wrap range");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !empty)
		else $error("popped word did not reach output");
`endif

endmodule

FILE: rtl/core/apyd_front.sv
// front end: byte window, packet match and checksum, pushes candidate yaw words
module apyd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  apyd_pkg::byte_t    rx_byte,
	input  apyd_pkg::qstat_t   qstat,
	output logic               q_push,
	output apyd_pkg::yaw_t     q_data
);

	apyd_pkg::byte_t window_q [apyd_pkg::WINDOW_BYTES];
	apyd_pkg::byte_t nxt [apyd_pkg::WINDOW_BYTES];
	logic            accept;
	logic            hdr_ok;
	logic [7:0]      sum;

	assign accept = push && !qstat.full;

	always_comb begin
		for (int i = 0; i < apyd_pkg::WINDOW_BYTES - 1; i++) begin
			nxt[i] = window_q[i + 1];
		end
		nxt[apyd_pkg::WINDOW_BYTES - 1] = rx_byte;
	end

	// match is judged on the window as it stands after this shift
	assign hdr_ok = (nxt[apyd_pkg::HDR_OFS_A] == apyd_pkg::HDR_BYTE)
		&& (nxt[apyd_pkg::HDR_OFS_B] == apyd_pkg::HDR_BYTE)
		&& (nxt[apyd_pkg::HDR_OFS_C] == apyd_pkg::HDR_BYTE)
		&& (nxt[apyd_pkg::TAG_OFS] == apyd_pkg::ANGLE_TAG);

	always_comb begin
		sum = apyd_pkg::HDR_BYTE + apyd_pkg::ANGLE_TAG;
		for (int k = 0; k < apyd_pkg::SUM_BYTES; k++) begin
			sum = sum + nxt[apyd_pkg::SUM_FIRST + k];
		end
	end

	assign q_push = accept && hdr_ok && (sum == nxt[apyd_pkg::CHK_OFS]);
	assign q_data = {nxt[apyd_pkg::YAW_HI_OFS], nxt[apyd_pkg::YAW_LO_OFS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < apyd_pkg::WINDOW_BYTES; i++) begin
				window_q[i] <= '0;
			end
		end else if (accept) begin
			window_q <= nxt;
		end
	end

endmodule

FILE: rtl/core/apyd_queue.sv
// short queue of matched yaw words between front and back ends
module apyd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_push,
	input  apyd_pkg::yaw_t     q_data,
	input  logic               q_pop,
	output apyd_pkg::yaw_t     q_head,
	output apyd_pkg::qstat_t   qstat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	apyd_pkg::yaw_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);
	assign q_head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_push) begin
			mem_q[wr_ptr_q] <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!q_push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/apyd_back.sv
// back end: reference register, wrapped offset and output register
module apyd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [15:0]         cfg_data,
	input  apyd_pkg::qstat_t    qstat,
	input  apyd_pkg::yaw_t      q_head,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output apyd_pkg::yaw_t      heading,
	output apyd_pkg::offset_t   yaw_offset
);

	logic [15:0]       yaw_reference_q;
	logic              out_valid_q;
	apyd_pkg::yaw_t    yaw_q;
	apyd_pkg::offset_t offset_q;
	apyd_pkg::offset_t diff;
	apyd_pkg::offset_t wrapped;

	assign diff = apyd_pkg::offset_t'({1'b0, q_head})
		- apyd_pkg::offset_t'({1'b0, yaw_reference_q});

	// one full turn either way is the same 17-bit add
	always_comb begin
		if (diff > apyd_pkg::WRAP_LIMIT) begin
			wrapped = diff - apyd_pkg::offset_t'(apyd_pkg::FULL_TURN);
		end else if (diff < -apyd_pkg::WRAP_LIMIT) begin
			wrapped = diff + apyd_pkg::offset_t'(apyd_pkg::FULL_TURN);
		end else begin
			wrapped = diff;
		end
	end

	assign q_pop      = !qstat.empty && (!out_valid_q || pop);
	assign empty      = !out_valid_q;
	assign heading    = yaw_q;
	assign yaw_offset = offset_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			yaw_q    <= q_head;
			offset_q <= wrapped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_reference_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_write) begin
				yaw_reference_q <= cfg_data;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for the yaw packet parser: directed packets, then random byte streams
module tb_top;

	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int PHASE_BYTES = 370;
	localparam int TURN_COUNTS = 65536;
	localparam int NUM_CASES = 13;

	typedef struct packed {
		apyd_pkg::yaw_t yaw;
		apyd_pkg::offset_t offset;
	} yaw_result_t;

	// one directed packet; want_* only count where typed is set
	typedef struct packed {
		logic wr;
		apyd_pkg::yaw_t reference;
		apyd_pkg::yaw_t yaw;
		logic bad_sum;
		logic typed;
		logic hit;
		apyd_pkg::yaw_t want_yaw;
		apyd_pkg::offset_t want_offset;
	} packet_case_t;

	localparam packet_case_t PACKET_CASES [NUM_CASES] = '{
		'{1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 17'sd0},
		'{1'b0, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, -17'sd1},
		'{1'b0, 16'h0000, 16'd54613, 1'b0, 1'b1, 1'b1, 16'd54613, 17'sd54613},
		'{1'b0, 16'h0000, 16'd54614, 1'b0, 1'b1, 1'b1, 16'd54614, -17'sd10922},
		'{1'b0, 16'h0000, 16'h1234, 1'b1, 1'b1, 1'b0, 16'h0000, 17'sd0},
		'{1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 1'b1, 16'h0000, 17'sd1},
		'{1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 16'hFFFF, 17'sd0},
		'{1'b0, 16'hFFFF, 16'd10922, 1'b0, 1'b1, 1'b1, 16'd10922, -17'sd54613},
		'{1'b0, 16'hFFFF, 16'd10921, 1'b0, 1'b1, 1'b1, 16'd10921, 17'sd10922},
		'{1'b1, 16'h8000, 16'h8000, 1'b0, 1'b1, 1'b1, 16'h8000, 17'sd0},
		'{1'b0, 16'h8000, 16'h5AA5, 1'b0, 1'b0, 1'b0, 16'h0000, 17'sd0},
		'{1'b0, 16'h8000, 16'hC3C3, 1'b1, 1'b0, 1'b0, 16'h0000, 17'sd0},
		'{1'b0, 16'h8000, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'h0000, 17'sd0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic push;
	logic full;
	apyd_pkg::byte_t rx_byte;
	logic empty;
	logic pop;
	apyd_pkg::yaw_t heading;
	apyd_pkg::offset_t yaw_offset;
	logic cfg_write;
	apyd_pkg::yaw_t cfg_data;

	// predictor state
	apyd_pkg::byte_t window_bytes [apyd_pkg::WINDOW_BYTES];
	apyd_pkg::yaw_t reference_model;
	yaw_result_t yaw_results_due [$];
	yaw_result_t want;
	int failures = 0;
	int stall_cycles = 0;

	// typed expectation for the next accepted byte
	logic pin_armed;
	logic pin_hit;
	yaw_result_t pin_result;
	logic hold_request;

	always #1 clk = ~clk;

	angle_packet_yaw_delta_parser_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.heading(heading),
		.yaw_offset(yaw_offset),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data)
	);

	function automatic logic window_holds_packet();
		apyd_pkg::byte_t sum;
		sum = apyd_pkg::HDR_BYTE + apyd_pkg::ANGLE_TAG;
		for (int k = apyd_pkg::SUM_FIRST; k < apyd_pkg::SUM_FIRST + apyd_pkg::SUM_BYTES; k++)
			sum += window_bytes[k];
		return window_bytes[apyd_pkg::HDR_OFS_A] == apyd_pkg::HDR_BYTE &&
			window_bytes[apyd_pkg::HDR_OFS_B] == apyd_pkg::HDR_BYTE &&
			window_bytes[apyd_pkg::HDR_OFS_C] == apyd_pkg::HDR_BYTE &&
			window_bytes[apyd_pkg::TAG_OFS] == apyd_pkg::ANGLE_TAG &&
			sum == window_bytes[apyd_pkg::CHK_OFS];
	endfunction

	function automatic yaw_result_t decode_yaw();
		yaw_result_t res;
		int diff;
		res.yaw = {window_bytes[apyd_pkg::YAW_HI_OFS], window_bytes[apyd_pkg::YAW_LO_OFS]};
		diff = int'(res.yaw) - int'(reference_model);
		// wrap by a full turn past 300 degrees either way
		if (diff > int'(apyd_pkg::WRAP_LIMIT))
			diff -= TURN_COUNTS;
		else if (diff < -int'(apyd_pkg::WRAP_LIMIT))
			diff += TURN_COUNTS;
		res.offset = apyd_pkg::offset_t'(diff);
		return res;
	endfunction

	function automatic apyd_pkg::yaw_t pick_yaw();
		apyd_pkg::yaw_t pick;
		case ($urandom_range(0, 5))
			0: pick = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			1: pick = reference_model + apyd_pkg::yaw_t'(apyd_pkg::WRAP_LIMIT)
				+ apyd_pkg::yaw_t'($urandom_range(0, 2)) - 16'd1;
			2: pick = reference_model - apyd_pkg::yaw_t'(apyd_pkg::WRAP_LIMIT)
				+ apyd_pkg::yaw_t'($urandom_range(0, 2)) - 16'd1;
			default: pick = apyd_pkg::yaw_t'($urandom);
		endcase
		return pick;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycles++;
			if (pop && !empty) begin
				stall_cycles = 0;
				if (yaw_results_due.size() == 0) begin
					failures++;
					$display("%0t: unexpected word, expected none, actual yaw %h offset %0d",
						$time, heading, yaw_offset);
				end else begin
					want = yaw_results_due.pop_front();
					if (heading !== want.yaw) begin
						failures++;
						$display("%0t: heading expected %h actual %h",
							$time, want.yaw, heading);
					end
					if (yaw_offset !== want.offset) begin
						failures++;
						$display("%0t: yaw_offset expected %0d actual %0d",
							$time, $signed(want.offset), yaw_offset);
					end
				end
			end
			if (push && !full) begin
				stall_cycles = 0;
				for (int k = 0; k < apyd_pkg::WINDOW_BYTES - 1; k++)
					window_bytes[k] = window_bytes[k + 1];
				window_bytes[apyd_pkg::WINDOW_BYTES - 1] = rx_byte;
				if (pin_armed) begin
					pin_armed = 1'b0;
					if (pin_hit)
						yaw_results_due.push_back(pin_result);
				end else if (window_holds_packet()) begin
					yaw_results_due.push_back(decode_yaw());
				end
			end
			if (cfg_write)
				reference_model = cfg_data;
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	// result side: random pops, one long hold-off to back the block up
	initial begin
		int gap;
		logic held;
		pop = 1'b0;
		held = 1'b0;
		forever begin
			gap = $urandom_range(0, 5);
			repeat (gap) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			if (hold_request && !held) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
		end
	end

	task automatic send_byte(input apyd_pkg::byte_t b, input logic arm, input logic hit,
			input yaw_result_t res);
		int gap;
		gap = $urandom_range(0, 5);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		rx_byte <= b;
		if (arm) begin
			pin_armed = 1'b1;
			pin_hit = hit;
			pin_result = res;
		end
		do @(posedge clk); while (full);
	endtask

	task automatic send_packet(input apyd_pkg::yaw_t yaw, input logic bad_sum, input int len,
			input logic arm, input logic hit, input yaw_result_t res);
		apyd_pkg::byte_t pkt [apyd_pkg::WINDOW_BYTES];
		apyd_pkg::byte_t sum;
		foreach (pkt[k])
			pkt[k] = apyd_pkg::byte_t'($urandom);
		pkt[apyd_pkg::HDR_OFS_A] = apyd_pkg::HDR_BYTE;
		pkt[apyd_pkg::HDR_OFS_B] = apyd_pkg::HDR_BYTE;
		pkt[apyd_pkg::HDR_OFS_C] = apyd_pkg::HDR_BYTE;
		pkt[apyd_pkg::TAG_OFS] = apyd_pkg::ANGLE_TAG;
		pkt[apyd_pkg::YAW_LO_OFS] = yaw[7:0];
		pkt[apyd_pkg::YAW_HI_OFS] = yaw[15:8];
		sum = apyd_pkg::HDR_BYTE + apyd_pkg::ANGLE_TAG;
		for (int k = apyd_pkg::SUM_FIRST; k < apyd_pkg::SUM_FIRST + apyd_pkg::SUM_BYTES; k++)
			sum += pkt[k];
		pkt[apyd_pkg::CHK_OFS] = bad_sum ? sum + apyd_pkg::byte_t'($urandom_range(1, 255)) : sum;
		for (int k = 0; k < len; k++)
			send_byte(pkt[k], arm && k == apyd_pkg::WINDOW_BYTES - 1, hit, res);
	endtask

	// stop sending and wait out every word still owed
	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (yaw_results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reference(input apyd_pkg::yaw_t value);
		drain_results();
		cfg_write <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int len;
		int kind;
		int noise_len;
		int phase_bytes;
		apyd_pkg::yaw_t phase_refs [4];
		yaw_result_t typed_res;
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = '0;
		cfg_write = 1'b0;
		cfg_data = '0;
		pin_armed = 1'b0;
		pin_hit = 1'b0;
		pin_result = '0;
		hold_request = 1'b0;
		reference_model = '0;
		foreach (window_bytes[k])
			window_bytes[k] = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NUM_CASES; r++) begin
			if (PACKET_CASES[r].wr)
				write_reference(PACKET_CASES[r].reference);
			typed_res.yaw = PACKET_CASES[r].want_yaw;
			typed_res.offset = PACKET_CASES[r].want_offset;
			send_packet(PACKET_CASES[r].yaw, PACKET_CASES[r].bad_sum, apyd_pkg::WINDOW_BYTES,
				PACKET_CASES[r].typed, PACKET_CASES[r].hit, typed_res);
		end

		phase_refs[0] = apyd_pkg::yaw_t'($urandom);
		phase_refs[1] = 16'h0000;
		phase_refs[2] = 16'hFFFF;
		phase_refs[3] = apyd_pkg::yaw_t'($urandom);
		for (int ph = 0; ph < 4; ph++) begin
			write_reference(phase_refs[ph]);
			// clean packets only while the result side holds off, so the queue fills
			if (ph == 1)
				hold_request = 1'b1;
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				kind = (ph == 1) ? 0 : $urandom_range(0, 9);
				if (kind < 8) begin
					len = (kind == 7) ? $urandom_range(1, apyd_pkg::WINDOW_BYTES - 1)
						: apyd_pkg::WINDOW_BYTES;
					send_packet(pick_yaw(), kind == 6, len, 1'b0, 1'b0, '0);
					phase_bytes += len;
				end else begin
					noise_len = $urandom_range(1, 8);
					repeat (noise_len)
						send_byte($urandom_range(0, 3) == 0 ? apyd_pkg::HDR_BYTE
							: apyd_pkg::byte_t'($urandom), 1'b0, 1'b0, '0);
					phase_bytes += noise_len;
				end
			end
		end

		drain_results();
		repeat (8) @(negedge clk);
		if (failures == 0 && yaw_results_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
